// File: design/lprf_pkg.sv
package lprf_pkg;

	// result status codes
	localparam logic [1:0] ST_HIT     = 2'd0;
	localparam logic [1:0] ST_FILLED  = 2'd1;
	localparam logic [1:0] ST_REPLACE = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_PROCESS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE        = 8'd1;

	// field widths
	localparam int unsigned PID_W   = 7;
	localparam int unsigned PAGE_W  = 20;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned QUOTA_W = 9;
	localparam int unsigned FIDX_W  = 8;

	// one frame table entry
	typedef struct packed {
		logic [PID_W-1:0]   owner;
		logic [PAGE_W-1:0]  page;
		logic [STAMP_W-1:0] stamp;
	} frame_entry_t;

endpackage

// File: design/lprf_frame_ram.sv
module lprf_frame_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  lprf_pkg::frame_entry_t wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output lprf_pkg::frame_entry_t rd_data
);

	lprf_pkg::frame_entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: design/local_page_replace_fifo_lru.sv
// Page replacement engine with local frame allocation, FIFO or LRU.
// Command channel: a reference (process_id, page_number) is taken at a
// rising edge where start is high and busy is low. busy stays high while
// the reference is worked on.
// Result channel: done is high for exactly one cycle with status,
// frame_index, old_page and fault_total; the receiver cannot hold it off.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Index 0 is frames_per_process, index 1 is
// policy_mode, other indexes are dropped. Write only while idle.
// Each reference taken is first worked through the frame table scan, which
// reads one entry per cycle through the single read port of the frame
// memory; the decide state follows and registers the result and done.
// A new start is taken in the cycle done is shown.
// Reset: fill count 0, stamp counter 1, fault counter 0, registers at
// their defaults; the frame memory needs no clearing because only frames
// below the fill count are ever read.
module local_page_replace_fifo_lru #(
	parameter int unsigned TOTAL_FRAMES = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [lprf_pkg::PID_W-1:0]        process_id,
	input  logic [lprf_pkg::PAGE_W-1:0]       page_number,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [lprf_pkg::FIDX_W-1:0]       frame_index,
	output logic [lprf_pkg::PAGE_W-1:0]       old_page,
	output logic [lprf_pkg::STAMP_W-1:0]      fault_total,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lprf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lprf_pkg::QUOTA_W-1:0]      cfg_data
);

	localparam int unsigned AW = $clog2(TOTAL_FRAMES);
	localparam int unsigned CW = $clog2(TOTAL_FRAMES + 1);
	localparam int unsigned CMPW = (CW > lprf_pkg::QUOTA_W) ? CW : lprf_pkg::QUOTA_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(TOTAL_FRAMES);
	localparam logic [lprf_pkg::STAMP_W-1:0] CNT_MAX = '1;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DECIDE = 2'd2;

	logic [1:0] state_q;

	// configuration registers
	logic [lprf_pkg::QUOTA_W-1:0] quota_cfg_q;
	logic                         lru_q;

	// persistent counters
	logic [CW-1:0]                fill_q;
	logic [lprf_pkg::STAMP_W-1:0] stamp_q;
	logic [lprf_pkg::STAMP_W-1:0] fault_q;

	// latched reference
	logic [lprf_pkg::PID_W-1:0]   pid_q;
	logic [lprf_pkg::PAGE_W-1:0]  page_q;

	// scan pipeline
	logic [CW-1:0]                iss_q;
	logic                         vld_s1;
	logic [AW-1:0]                idx_s1;

	// scan accumulators
	logic                         hit_q;
	logic [AW-1:0]                hit_idx_q;
	logic [CW-1:0]                owned_q;
	logic                         have_v_q;
	logic [lprf_pkg::STAMP_W-1:0] best_q;
	logic [AW-1:0]                victim_q;
	logic [lprf_pkg::PAGE_W-1:0]  vpage_q;

	// result registers
	logic                         done_q;
	logic [1:0]                   status_q;
	logic [lprf_pkg::FIDX_W-1:0]  fidx_q;
	logic [lprf_pkg::PAGE_W-1:0]  old_q;

	// memory ports
	logic                         rd_en;
	lprf_pkg::frame_entry_t       rd_data;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	lprf_pkg::frame_entry_t       wr_data;

	// decision logic
	logic [lprf_pkg::QUOTA_W-1:0] quota;
	logic                         below_quota;
	logic                         can_fill;
	logic [1:0]                   dec_status;
	logic [AW-1:0]                dec_idx;
	logic [lprf_pkg::PAGE_W-1:0]  dec_old;
	logic [lprf_pkg::STAMP_W-1:0] stamp_inc;
	logic [lprf_pkg::STAMP_W-1:0] fault_inc;
	logic                         owner_match;

	assign busy        = (state_q != S_IDLE);
	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign status      = status_q;
	assign frame_index = fidx_q;
	assign old_page    = old_q;
	assign fault_total = fault_q;

	lprf_frame_ram #(
		.DEPTH (TOTAL_FRAMES),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (iss_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// reads only in scan, writes only in decide, so no same-entry overlap
	assign rd_en       = (state_q == S_SCAN) && (iss_q < fill_q);
	assign owner_match = (rd_data.owner == pid_q);

	// replacement decision
	assign quota       = (quota_cfg_q == '0) ? lprf_pkg::QUOTA_W'(1) : quota_cfg_q;
	assign below_quota = (CMPW'(owned_q) < CMPW'(quota)) || !have_v_q;
	assign can_fill    = (fill_q < FULL_CNT);
	assign stamp_inc   = (stamp_q == CNT_MAX) ? stamp_q : stamp_q + 1'b1;
	assign fault_inc   = (fault_q == CNT_MAX) ? fault_q : fault_q + 1'b1;

	always_comb begin
		dec_status = lprf_pkg::ST_HIT;
		dec_idx    = hit_idx_q;
		dec_old    = '0;
		wr_en      = 1'b0;
		priority if (hit_q) begin
			wr_en = lru_q;
		end else if (below_quota && can_fill) begin
			dec_status = lprf_pkg::ST_FILLED;
			dec_idx    = fill_q[AW-1:0];
			wr_en      = 1'b1;
		end else if (below_quota) begin
			dec_status = lprf_pkg::ST_FULL;
			dec_idx    = '0;
		end else begin
			dec_status = lprf_pkg::ST_REPLACE;
			dec_idx    = victim_q;
			dec_old    = vpage_q;
			wr_en      = 1'b1;
		end
		wr_en = wr_en && (state_q == S_DECIDE);
	end

	assign wr_addr       = dec_idx;
	assign wr_data.owner = pid_q;
	assign wr_data.page  = page_q;
	assign wr_data.stamp = stamp_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quota_cfg_q <= lprf_pkg::QUOTA_W'(4);
			lru_q       <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == lprf_pkg::REG_FRAMES_PER_PROCESS) begin
				quota_cfg_q <= cfg_data;
			end else if (cfg_index == lprf_pkg::REG_POLICY_MODE) begin
				lru_q <= cfg_data[0];
			end
		end
	end

	// sequencer, scan pipeline and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			stamp_q  <= lprf_pkg::STAMP_W'(1);
			fault_q  <= '0;
			iss_q    <= '0;
			vld_s1   <= 1'b0;
			hit_q    <= 1'b0;
			have_v_q <= 1'b0;
			owned_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q  <= S_SCAN;
						iss_q    <= '0;
						vld_s1   <= 1'b0;
						hit_q    <= 1'b0;
						have_v_q <= 1'b0;
						owned_q  <= '0;
					end
				end
				S_SCAN: begin
					vld_s1 <= rd_en;
					if (rd_en) begin
						iss_q <= iss_q + 1'b1;
					end
					// fold in the entry read last cycle
					if (vld_s1 && owner_match) begin
						owned_q <= owned_q + 1'b1;
						if (!hit_q && rd_data.page == page_q) begin
							hit_q <= 1'b1;
						end
						if (!have_v_q || rd_data.stamp < best_q) begin
							have_v_q <= 1'b1;
						end
					end
					if (!rd_en && !vld_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (!hit_q) begin
						fault_q <= fault_inc;
						stamp_q <= stamp_inc;
						if (below_quota && can_fill) begin
							fill_q <= fill_q + 1'b1;
						end
					end else if (lru_q) begin
						stamp_q <= stamp_inc;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			pid_q  <= process_id;
			page_q <= page_number;
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= iss_q[AW-1:0];
			if (vld_s1 && owner_match) begin
				if (!hit_q && rd_data.page == page_q) begin
					hit_idx_q <= idx_s1;
				end
				if (!have_v_q || rd_data.stamp < best_q) begin
					best_q   <= rd_data.stamp;
					victim_q <= idx_s1;
					vpage_q  <= rd_data.page;
				end
			end
		end
		if (state_q == S_DECIDE) begin
			status_q <= dec_status;
			fidx_q   <= lprf_pkg::FIDX_W'(dec_idx);
			old_q    <= dec_old;
		end
	end

	// checks
	a_wr_only_decide: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_DECIDE))
		else $error("frame write outside decide");

	a_done_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |=> done_q)
		else $error("decide not followed by result");

	a_fill_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DECIDE) |=> $stable(fill_q))
		else $error("fill count moved outside decide");

	a_fault_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DECIDE) |=> $stable(fault_q))
		else $error("fault counter moved outside decide");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("read and write of frame table overlap");

endmodule

// File: tb/tb_local_page_replace_fifo_lru.sv
module tb_local_page_replace_fifo_lru;

	import lprf_pkg::*;

	localparam int unsigned TOTAL_FRAMES = 256;
	localparam int unsigned CYCLE_LIMIT  = 2000000;
	localparam int unsigned TAIL_CYCLES  = 300;

	// register indexes the block has no register for
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

	typedef enum logic [1:0] {OP_LOOKUP, OP_CFG, OP_DRAIN, OP_PACE} stim_kind_t;

	typedef struct {
		stim_kind_t           kind;
		logic [PID_W-1:0]     pid;
		logic [PAGE_W-1:0]    page;
		logic [CFG_IDX_W-1:0] idx;
		logic [QUOTA_W-1:0]   data;
		int unsigned          pct;
	} stim_op_t;

	typedef struct {
		logic [1:0]         status;
		logic [FIDX_W-1:0]  frame;
		logic [PAGE_W-1:0]  old_page;
		logic [STAMP_W-1:0] faults;
	} lookup_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [PID_W-1:0]     process_id = '0;
	logic [PAGE_W-1:0]    page_number = '0;
	logic                 done;
	logic [1:0]           status;
	logic [FIDX_W-1:0]    frame_index;
	logic [PAGE_W-1:0]    old_page;
	logic [STAMP_W-1:0]   fault_total;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [QUOTA_W-1:0]   cfg_data = '0;

	local_page_replace_fifo_lru #(
		.TOTAL_FRAMES(TOTAL_FRAMES)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.process_id  (process_id),
		.page_number (page_number),
		.done        (done),
		.status      (status),
		.frame_index (frame_index),
		.old_page    (old_page),
		.fault_total (fault_total),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// shadow frame table and registers
	logic [PID_W-1:0]   tbl_owner [TOTAL_FRAMES];
	logic [PAGE_W-1:0]  tbl_page  [TOTAL_FRAMES];
	logic [STAMP_W-1:0] tbl_stamp [TOTAL_FRAMES];
	int unsigned        tbl_fill = 0;
	logic [STAMP_W-1:0] age_ctr = 32'd1;
	logic [STAMP_W-1:0] fault_ctr = '0;
	logic [QUOTA_W-1:0] quota_reg = 9'd4;
	logic               lru_mode = 1'b0;

	stim_op_t       stim_q [$];
	lookup_result_t lookup_expect_q [$];
	int unsigned    send_idle_pct = 0;
	int unsigned    err_count = 0;
	int unsigned    cycle_count = 0;
	logic           cmd_taken = 1'b0;
	logic           cfg_taken = 1'b0;

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// resolve one page reference against the shadow table
	function automatic lookup_result_t lookup_page(input logic [PID_W-1:0] pid,
			input logic [PAGE_W-1:0] pg);
		lookup_result_t res;
		int unsigned    eff_quota;
		int unsigned    owned;
		int unsigned    hit_idx;
		int unsigned    victim;
		logic           hit;
		logic           have_victim;
		logic [STAMP_W-1:0] best;
		res = '{status: ST_HIT, frame: '0, old_page: '0, faults: '0};
		eff_quota = (quota_reg == 0) ? 1 : int'(quota_reg);
		owned = 0;
		hit_idx = 0;
		victim = 0;
		hit = 1'b0;
		have_victim = 1'b0;
		best = '0;
		// one pass: hit search, owned count, oldest stamp
		for (int unsigned j = 0; j < tbl_fill; j++) begin
			if (tbl_owner[j] == pid) begin
				if (!hit && tbl_page[j] == pg) begin
					hit = 1'b1;
					hit_idx = j;
				end
				owned++;
				if (!have_victim || tbl_stamp[j] < best) begin
					have_victim = 1'b1;
					best = tbl_stamp[j];
					victim = j;
				end
			end
		end
		if (hit) begin
			res.status = ST_HIT;
			res.frame = hit_idx[FIDX_W-1:0];
			if (lru_mode) begin
				tbl_stamp[hit_idx] = age_ctr;
				if (age_ctr != '1) age_ctr++;
			end
		end else begin
			if (fault_ctr != '1) fault_ctr++;
			if (owned < eff_quota || !have_victim) begin
				if (tbl_fill < TOTAL_FRAMES) begin
					tbl_owner[tbl_fill] = pid;
					tbl_page[tbl_fill] = pg;
					tbl_stamp[tbl_fill] = age_ctr;
					res.status = ST_FILLED;
					res.frame = tbl_fill[FIDX_W-1:0];
					tbl_fill++;
				end else begin
					res.status = ST_FULL;
				end
			end else begin
				res.status = ST_REPLACE;
				res.frame = victim[FIDX_W-1:0];
				res.old_page = tbl_page[victim];
				tbl_page[victim] = pg;
				tbl_stamp[victim] = age_ctr;
			end
			if (age_ctr != '1) age_ctr++;
		end
		res.faults = fault_ctr;
		return res;
	endfunction

	// driver: one command word or one register word at a time
	always @(negedge clk) begin : drive_proc
		logic     nxt_start;
		logic     nxt_cfg;
		stim_op_t op;
		nxt_start = start;
		nxt_cfg = cfg_valid;
		if (arst_n) begin
			if (cmd_taken) nxt_start = 1'b0;
			if (cfg_taken) nxt_cfg = 1'b0;
			if (!nxt_start && !nxt_cfg && stim_q.size() > 0) begin
				op = stim_q[0];
				case (op.kind)
				OP_LOOKUP: begin
					if ($urandom_range(99) >= send_idle_pct) begin
						nxt_start = 1'b1;
						process_id <= op.pid;
						page_number <= op.page;
						void'(stim_q.pop_front());
					end
				end
				OP_CFG: begin
					// registers change only while nothing is in flight
					if (lookup_expect_q.size() == 0 && !busy) begin
						nxt_cfg = 1'b1;
						cfg_index <= op.idx;
						cfg_data <= op.data;
						void'(stim_q.pop_front());
					end
				end
				OP_DRAIN: begin
					if (lookup_expect_q.size() == 0 && !busy) void'(stim_q.pop_front());
				end
				default: begin
					send_idle_pct = op.pct;
					void'(stim_q.pop_front());
				end
				endcase
			end
		end
		start <= nxt_start;
		cfg_valid <= nxt_cfg;
	end

	// monitor: check results, predict accepted words, track register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_taken <= 1'b0;
			cfg_taken <= 1'b0;
		end else begin
			if (done) begin
				if (lookup_expect_q.size() == 0) begin
					flag_error($sformatf("unexpected result status=%0d frame=%0d",
						status, frame_index));
				end else begin : check_blk
					lookup_result_t want;
					want = lookup_expect_q.pop_front();
					if (status !== want.status)
						flag_error($sformatf("status got %0d want %0d", status, want.status));
					if (frame_index !== want.frame)
						flag_error($sformatf("frame_index got %0d want %0d",
							frame_index, want.frame));
					if (old_page !== want.old_page)
						flag_error($sformatf("old_page got %h want %h", old_page, want.old_page));
					if (fault_total !== want.faults)
						flag_error($sformatf("fault_total got %0d want %0d",
							fault_total, want.faults));
				end
			end
			if (start && !busy)
				lookup_expect_q.insert(lookup_expect_q.size(),
					lookup_page(process_id, page_number));
			cmd_taken <= start && !busy;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FRAMES_PER_PROCESS) quota_reg = cfg_data;
				else if (cfg_index == REG_POLICY_MODE) lru_mode = cfg_data[0];
			end
			cfg_taken <= cfg_valid && cfg_ready;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic push_lookup(input logic [PID_W-1:0] pid, input logic [PAGE_W-1:0] pg);
		stim_op_t op;
		op = '{kind: OP_LOOKUP, pid: pid, page: pg, idx: '0, data: '0, pct: 0};
		stim_q.insert(stim_q.size(), op);
	endtask

	task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [QUOTA_W-1:0] data);
		stim_op_t op;
		op = '{kind: OP_CFG, pid: '0, page: '0, idx: idx, data: data, pct: 0};
		stim_q.insert(stim_q.size(), op);
	endtask

	// wait for every result, then change the sender pacing
	task automatic push_pace(input int unsigned pct);
		stim_op_t op;
		op = '{kind: OP_DRAIN, pid: '0, page: '0, idx: '0, data: '0, pct: 0};
		stim_q.insert(stim_q.size(), op);
		op = '{kind: OP_PACE, pid: '0, page: '0, idx: '0, data: '0, pct: pct};
		stim_q.insert(stim_q.size(), op);
	endtask

	initial begin
		logic [PID_W-1:0]  pid;
		logic [PAGE_W-1:0] pg;
		int unsigned       pick;

		// directed: fifo fill, hit and replace at the field extremes
		push_lookup(7'd0, 20'd0);
		push_lookup(7'd0, 20'd0);
		push_lookup(7'd127, 20'hFFFFF);
		push_lookup(7'd127, 20'hFFFFF);
		push_lookup(7'd0, 20'd1);
		push_lookup(7'd0, 20'd2);
		push_lookup(7'd0, 20'd3);
		push_lookup(7'd0, 20'd0);
		push_lookup(7'd0, 20'd4);
		push_lookup(7'd0, 20'd1);
		// lru: a hit restamps, so the next fault skips that frame
		push_cfg(REG_POLICY_MODE, 9'd1);
		push_lookup(7'd0, 20'd2);
		push_lookup(7'd0, 20'd5);
		push_lookup(7'd0, 20'd2);
		// zero quota acts as one
		push_cfg(REG_FRAMES_PER_PROCESS, 9'd0);
		push_lookup(7'd5, 20'd7);
		push_lookup(7'd5, 20'd8);
		push_lookup(7'd5, 20'd8);
		// unused indexes are dropped
		push_cfg(REG_UNUSED_LO, 9'h1FF);
		push_cfg(REG_UNUSED_HI, 9'h000);
		push_lookup(7'd5, 20'd9);
		// quota beyond the table size
		push_cfg(REG_FRAMES_PER_PROCESS, 9'h1FF);
		push_cfg(REG_POLICY_MODE, 9'h1FE);
		push_lookup(7'd64, 20'h80000);
		push_lookup(7'd64, 20'h7FFFF);
		push_lookup(7'd64, 20'h80000);

		// random blocks; block 8 fills the table to the end
		for (int unsigned blk = 0; blk < 11; blk++) begin
			if (blk == 0) push_pace(22);
			else if (blk == 3) push_pace(46);
			else if (blk == 6) push_pace(0);
			if (blk == 8) begin
				push_cfg(REG_FRAMES_PER_PROCESS, 9'h1FF);
				push_cfg(REG_POLICY_MODE, 9'($urandom_range(511)));
				for (int unsigned i = 0; i < 220; i++) begin
					pid = 7'($urandom_range(7));
					pg = (i % 5 == 4) ? 20'($urandom_range(7)) : (20'hC0000 | 20'(i));
					push_lookup(pid, pg);
				end
			end else begin
				pick = $urandom_range(9);
				case (pick)
				0: push_cfg(REG_FRAMES_PER_PROCESS, 9'd0);
				1: push_cfg(REG_FRAMES_PER_PROCESS, 9'd1);
				2: push_cfg(REG_FRAMES_PER_PROCESS, 9'd256);
				3: push_cfg(REG_FRAMES_PER_PROCESS, 9'h1FF);
				default: push_cfg(REG_FRAMES_PER_PROCESS, 9'($urandom_range(8, 2)));
				endcase
				push_cfg(REG_POLICY_MODE, 9'($urandom_range(511)));
				if ($urandom_range(3) == 0)
					push_cfg(8'($urandom_range(255, 2)), 9'($urandom_range(511)));
				for (int unsigned i = 0; i < 50; i++) begin
					pid = ($urandom_range(99) < 85) ? 7'($urandom_range(7))
						: 7'($urandom_range(127));
					pick = $urandom_range(99);
					if (pick < 70) pg = 20'($urandom_range(7));
					else if (pick < 90) pg = 20'($urandom);
					else pg = $urandom_range(1) ? 20'hFFFFF : 20'd0;
					push_lookup(pid, pg);
				end
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// drain, then let the block settle
		while (stim_q.size() > 0 || start || cfg_valid || busy || lookup_expect_q.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
